// File: rtl/urlu_pkg.sv
// Shared types, constants and decode helpers for the URL unescape block.
`default_nettype none
package urlu_pkg;

  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChPercent   = 8'h25;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] CaseMask    = 8'hDF;
  localparam logic [7:0] AlphaBias   = 8'd10;

  // One queued output byte; bs requests a backslash ahead of it.
  typedef struct packed {
    logic       bs;
    logic [7:0] data;
  } entry_t;

  // Front to queue push request.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Hex digit value, no range check, modulo 256.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= ChUpperA) begin
      v = (c & CaseMask) - ChUpperA + AlphaBias;
    end else begin
      v = c - ChZero;
    end
    return v;
  endfunction

  // Shell metacharacters: & ; ` ' | * ? - ~ < > ^ ( ) [ ] { } $ and backslash.
  function automatic logic is_shell_meta(input logic [7:0] c);
    logic m;
    case (c) inside
      8'h26, 8'h3B, 8'h60, 8'h27, 8'h7C, 8'h2A, 8'h3F, 8'h2D, 8'h7E, 8'h3C,
      8'h3E, 8'h5E, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h24,
      ChBackslash: m = 1'b1;
      default:     m = 1'b0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/url_unescape_shell_escape.sv
// Top level of the URL percent decoder with optional shell escaping.
//
// Takes one encoded byte per transaction (in_last_i marks the end of the
// string) and returns decoded bytes: '+' maps to space, '%' plus two digits
// gives one byte (digits unchecked, value modulo 256). With shell escaping
// enabled a backslash transaction precedes each decoded shell metacharacter.
// A string that ends inside an escape gives exactly one byte, the partial
// value (0 after a lone '%', hi*16 after one digit), never escaped. Rate:
// one input byte per cycle while the FIFO is not full; each inserted
// backslash adds one transaction to the single output register. Accepted
// bytes pass through the FIFO, then the output register. A QUEUE_DEPTH-entry
// FIFO between the decode front and the output back end absorbs backslash
// bursts and output stalls; in_stall_o rises only when that FIFO is full.
// The config write port is always ready; write only while the block is idle.
`default_nettype none
module url_unescape_shell_escape #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_shell_escape_enable_i,
  // input stream
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  // output stream
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o
);

  logic                 shell_en_q;
  logic                 accept;
  logic                 pop;
  urlu_pkg::push_t      push;
  urlu_pkg::entry_t     head;
  urlu_pkg::q_stat_t    stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shell_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      shell_en_q <= cfg_shell_escape_enable_i;
    end
  end

  // Stall only on a full queue, so a byte that yields nothing still flows.
  assign in_stall_o = stat.full;
  assign accept     = in_valid_i && !in_stall_o;

  urlu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .shell_en_i (shell_en_q),
    .push_o     (push)
  );

  urlu_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  urlu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

endmodule
`default_nettype wire

// File: rtl/urlu_front.sv
// Front end: accepts input bytes, tracks percent escapes, classifies output bytes.
`default_nettype none
module urlu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_last_i,
  input  wire logic            shell_en_i,
  output urlu_pkg::push_t      push_o
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhPct  = 2'd1,
    PhHigh = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] partial_q, partial_d;
  logic [7:0] b;
  logic [7:0] dig;
  logic [7:0] val;
  logic       emit;
  logic       trunc;

  always_comb begin
    b         = (in_byte_i == urlu_pkg::ChPlus) ? urlu_pkg::ChSpace : in_byte_i;
    dig       = urlu_pkg::digit_value(b);
    phase_d   = PhIdle;
    partial_d = partial_q;
    val       = b;
    emit      = 1'b0;
    case (phase_q)
      PhPct: begin
        phase_d   = PhHigh;
        partial_d = {dig[3:0], 4'b0000};
      end
      PhHigh: begin
        val       = partial_q + dig;
        emit      = 1'b1;
        partial_d = '0;
      end
      default: begin
        if (b == urlu_pkg::ChPercent) begin
          phase_d   = PhPct;
          partial_d = '0;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    // String ends mid-escape: flush the partial value, unescaped.
    trunc = in_last_i && (phase_d != PhIdle);
    if (trunc) begin
      val       = partial_d;
      emit      = 1'b1;
      phase_d   = PhIdle;
      partial_d = '0;
    end
    push_o.valid      = accept_i && emit;
    push_o.entry.data = val;
    push_o.entry.bs   = shell_en_i && !trunc && urlu_pkg::is_shell_meta(val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      partial_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/urlu_queue.sv
// Small FIFO decoupling the decode front from the output back end.
`default_nettype none
module urlu_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire urlu_pkg::push_t  push_i,
  input  wire logic             pop_i,
  output urlu_pkg::entry_t      head_o,
  output urlu_pkg::q_stat_t     stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  urlu_pkg::entry_t mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/urlu_back.sv
// Back end: drains the queue, inserts backslashes, holds the output register.
`default_nettype none
module urlu_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire urlu_pkg::entry_t  head_i,
  input  wire urlu_pkg::q_stat_t stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte_o
);

  logic       valid_q, valid_d;
  logic       sent_q, sent_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  always_comb begin
    load    = !valid_q || !out_stall_i;
    valid_d = valid_q;
    sent_d  = sent_q;
    byte_d  = byte_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !stat_i.empty;
      if (!stat_i.empty) begin
        if (head_i.bs && !sent_q) begin
          byte_d = urlu_pkg::ChBackslash;
          sent_d = 1'b1;
        end else begin
          byte_d = head_i.data;
          sent_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;

endmodule
`default_nettype wire

// File: rtl/urlu_checker.sv
// Port-level checker for the URL unescape block, bound to the top level.
`default_nettype none
module urlu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o
);

  // Stalled output transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output changed while stalled");

  // Queue fills only through accepted input.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without prior input transaction");

  // Quiet once reset has been seen for a full edge.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

  // Config port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind url_unescape_shell_escape urlu_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o)
);
`default_nettype wire
